[sv/tpkm_pkg.sv]
// ---------------------------------------------------------------------------
// tpkm_pkg: shared types and constants for the TCP payload keyword matcher
// Holds the byte/item types and the fixed search keyword.
// ---------------------------------------------------------------------------
`default_nettype none

package tpkm_pkg;

  localparam int KEY_LEN = 15;
  localparam int WIN_LEN = KEY_LEN - 1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } item_t;

  // "HTTP/1.1 200 OK"
  localparam byte_t KEYWORD [KEY_LEN] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31,
    8'h20, 8'h32, 8'h30, 8'h30, 8'h20, 8'h4F, 8'h4B
  };

endpackage

`default_nettype wire

[sv/tpkm_scan.sv]
// ---------------------------------------------------------------------------
// tpkm_scan: per-packet scan state and keyword compare
// Counts packet bytes, keeps a sliding window of payload bytes, tracks zero
// bytes and oversize, and gives the verdict for a transaction marked last.
// ---------------------------------------------------------------------------
`default_nettype none

module tpkm_scan #(
  parameter int MAX_PAYLOAD  = 4096,
  parameter int HEADER_BYTES = 40
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire tpkm_pkg::item_t item,
  output logic                 found
);

  localparam int LIMIT = HEADER_BYTES + MAX_PAYLOAD;
  localparam int CW    = $clog2(LIMIT + 1);

  logic [CW-1:0]   bytes_seen, bytes_seen_next;
  logic            oversize_flag, oversize_flag_next;
  logic            zero_byte_seen, zero_byte_seen_next;
  logic            hit_flag, hit_flag_next;
  tpkm_pkg::byte_t recent_bytes      [tpkm_pkg::WIN_LEN];
  tpkm_pkg::byte_t recent_bytes_next [tpkm_pkg::WIN_LEN];
  logic            win_match;
  logic            in_payload;

  always_comb begin
    win_match = (item.data == tpkm_pkg::KEYWORD[tpkm_pkg::KEY_LEN-1]);
    for (int i = 0; i < tpkm_pkg::WIN_LEN; i++) begin
      if (recent_bytes[i] != tpkm_pkg::KEYWORD[i]) begin
        win_match = 1'b0;
      end
    end
  end

  always_comb begin
    bytes_seen_next     = bytes_seen;
    oversize_flag_next  = oversize_flag;
    zero_byte_seen_next = zero_byte_seen;
    hit_flag_next       = hit_flag;
    recent_bytes_next   = recent_bytes;
    in_payload          = (bytes_seen >= CW'(HEADER_BYTES));
    if (bytes_seen >= CW'(LIMIT)) begin
      oversize_flag_next = 1'b1;
    end else begin
      if (in_payload) begin
        zero_byte_seen_next = zero_byte_seen | (item.data == 8'h00);
        if (!zero_byte_seen_next) begin
          hit_flag_next = hit_flag | win_match;
          for (int i = 0; i < tpkm_pkg::WIN_LEN - 1; i++) begin
            recent_bytes_next[i] = recent_bytes[i+1];
          end
          recent_bytes_next[tpkm_pkg::WIN_LEN-1] = item.data;
        end
      end
      bytes_seen_next = bytes_seen + CW'(1);
    end
    found = hit_flag_next & ~oversize_flag_next & (bytes_seen_next > CW'(HEADER_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      oversize_flag  <= 1'b0;
      zero_byte_seen <= 1'b0;
      hit_flag       <= 1'b0;
      for (int i = 0; i < tpkm_pkg::WIN_LEN; i++) begin
        recent_bytes[i] <= '0;
      end
    end else if (en) begin
      if (item.last) begin
        bytes_seen     <= '0;
        oversize_flag  <= 1'b0;
        zero_byte_seen <= 1'b0;
        hit_flag       <= 1'b0;
        for (int i = 0; i < tpkm_pkg::WIN_LEN; i++) begin
          recent_bytes[i] <= '0;
        end
      end else begin
        bytes_seen     <= bytes_seen_next;
        oversize_flag  <= oversize_flag_next;
        zero_byte_seen <= zero_byte_seen_next;
        hit_flag       <= hit_flag_next;
        recent_bytes   <= recent_bytes_next;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tcp_payload_keyword_matcher.sv]
// ---------------------------------------------------------------------------
// tcp_payload_keyword_matcher: keyword search in a TCP payload
// Skips the fixed IP+TCP header and reports whether "HTTP/1.1 200 OK"
// occurs in the payload before its first zero byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one packet byte per transaction,
//   with end_of_packet set on the final byte. Output channel
//   (out_valid/out_ready) gives one keyword_found transaction per packet,
//   and nothing for the other bytes.
//   Throughput: one byte per clock cycle, except while a final byte waits behind a held verdict.
//   The verdict is registered: the last byte passes through the input register,
//   then the scan logic into the result register.
//   A payload longer than MAX_PAYLOAD, an empty payload or a packet no
//   longer than HEADER_BYTES gives 0.
//   Reset clears the scan state and the valid bits of both register stages.
//   When out_ready is low the verdict holds; non-final bytes keep flowing,
//   and only a second final byte waits in the input register, after which
//   in_ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_payload_keyword_matcher #(
  parameter int MAX_PAYLOAD  = 4096,
  parameter int HEADER_BYTES = 40
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] packet_byte,
  input  wire logic       end_of_packet,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            keyword_found
);

  tpkm_pkg::item_t s1_item;
  logic            s1_valid;
  logic            s1_adv;
  logic            found;

  assign s1_adv   = s1_valid & (~s1_item.last | ~out_valid | out_ready);
  assign in_ready = ~s1_valid | s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.data <= packet_byte;
      s1_item.last <= end_of_packet;
    end
  end

  tpkm_scan #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_adv),
    .item  (s1_item),
    .found (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.last) begin
      keyword_found <= found;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_item.last) |=> out_valid)
    else $error("final byte did not produce a verdict");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_item.last && out_valid && !out_ready))
    else $error("input stalled without a blocked verdict");

endmodule

`default_nettype wire
